// ===== design/csv_field_splitter_core_macros.svh =====
// ----------------------------------------------------------------------------
// csv_field_splitter_core assertion macros
// Shared concurrent assertion forms for the field splitter.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

// Check a property on every clock edge, skip while reset is asserted.
`define CSVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CSVS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// Widths, characters and the result type of the field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvs_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic [CHAR_W-1:0] QUOTE_CH = 8'h22;
    localparam logic [CHAR_W-1:0] COMMA_CH = 8'h2C;

    localparam logic [CNT_W-1:0] FIELD_CAP_RST = 5'd8;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic [IDX_W-1:0]  field_index;
        logic              field_end;
        logic              line_end;
        logic [CNT_W-1:0]  field_count;
        logic              error;
    } t_result;

endpackage

`default_nettype wire

// ===== design/csvs_char_if.sv =====
// ----------------------------------------------------------------------------
// csvs_char_if
// Character channel: one byte of a line and its last-character flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvs_char_if;

    logic                        valid;
    logic                        ready;
    logic [csvs_pkg::CHAR_W-1:0] ch;
    logic                        last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);

endinterface

`default_nettype wire

// ===== design/csvs_tok_if.sv =====
// ----------------------------------------------------------------------------
// csvs_tok_if
// Token channel: one tagged content byte with field and line markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvs_tok_if;

    logic                        valid;
    logic                        ready;
    logic [csvs_pkg::CHAR_W-1:0] out_char;
    logic                        char_valid;
    logic [csvs_pkg::IDX_W-1:0]  field_index;
    logic                        field_end;
    logic                        line_end;
    logic [csvs_pkg::CNT_W-1:0]  field_count;
    logic                        error;

    modport source (
        output valid, output out_char, output char_valid, output field_index,
        output field_end, output line_end, output field_count, output error,
        input  ready
    );
    modport sink (
        input  valid, input out_char, input char_valid, input field_index,
        input  field_end, input line_end, input field_count, input error,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/csvs_parser.sv =====
// ----------------------------------------------------------------------------
// csvs_parser
// Per-line parse state and the decode of one character into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module csvs_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [csvs_pkg::CHAR_W-1:0] i_ch,
    input  wire logic                        i_last,
    input  wire logic [csvs_pkg::CNT_W-1:0]  i_limit,
    output      csvs_pkg::t_result           o_res
);
    import csvs_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_PLAIN,
        PH_QUOTED,
        PH_QSEEN
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_fields, n_fields;
    logic             r_err, n_err;

    logic [CHAR_W-1:0] oc;
    logic              valid;
    logic              fend;

    always_comb begin
        n_phase  = r_phase;
        n_fields = r_fields;
        n_err    = r_err;
        oc       = '0;
        valid    = 1'b0;
        fend     = 1'b0;
        if (!r_err) begin
            case (r_phase)
                PH_START: begin
                    if (r_fields >= i_limit) begin
                        n_err = 1'b1;
                    end else begin
                        n_fields = r_fields + CNT_W'(1);
                        if (i_ch == QUOTE_CH) begin
                            n_phase = PH_QUOTED;
                        end else if (i_ch == COMMA_CH) begin
                            fend = 1'b1;
                        end else begin
                            oc      = i_ch;
                            valid   = 1'b1;
                            n_phase = PH_PLAIN;
                        end
                    end
                end
                PH_PLAIN: begin
                    if (i_ch == COMMA_CH) begin
                        fend    = 1'b1;
                        n_phase = PH_START;
                    end else begin
                        oc    = i_ch;
                        valid = 1'b1;
                    end
                end
                PH_QUOTED: begin
                    if (i_ch == QUOTE_CH) begin
                        n_phase = PH_QSEEN;
                    end else begin
                        oc    = i_ch;
                        valid = 1'b1;
                    end
                end
                PH_QSEEN: begin
                    // doubled quote is a literal, comma closes, anything else is junk
                    if (i_ch == QUOTE_CH) begin
                        oc      = QUOTE_CH;
                        valid   = 1'b1;
                        n_phase = PH_QUOTED;
                    end else if (i_ch == COMMA_CH) begin
                        fend    = 1'b1;
                        n_phase = PH_START;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
        // end of line closes a field that is still open
        if (i_last && !n_err && n_phase != PH_START) begin
            fend = 1'b1;
        end
    end

    always_comb begin
        o_res.out_char    = oc;
        o_res.char_valid  = valid;
        o_res.field_index = (n_fields == '0) ? '0 : IDX_W'(n_fields - CNT_W'(1));
        o_res.field_end   = fend;
        o_res.line_end    = i_last;
        o_res.field_count = n_fields;
        o_res.error       = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_fields <= '0;
            r_err    <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase  <= PH_START;
                r_fields <= '0;
                r_err    <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_fields <= n_fields;
                r_err    <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/csv_field_splitter_core.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// Splits a CSV line into tagged field content, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one byte of a line per item, last_char set on its final byte.
//   o_out returns exactly one result per input byte, in order: the content byte
//   (char_valid), its field index, field and line end marks, the running field
//   count and the sticky error flag of the line.
//   i_cfg_we / i_cfg_wdata write the field cap; write it only while the block
//   is idle. The effective limit is the smaller of the field cap and FIELD_LIMIT.
// Pipeline and throughput:
//   An accepted byte sits in the input register, is parsed, and lands in the
//   result register once that register is free or being drained. One byte is
//   accepted every cycle while o_out.ready stays high; the parse state loop in
//   csvs_parser updates once per byte.
// Reset:
//   Synchronous, active low. Both stages empty, parse state at field start,
//   field cap back to 8. i_in.ready is high right after reset.
// Stall:
//   When o_out.ready is low the result register holds, the input register
//   fills, and i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csv_field_splitter_core_macros.svh"

module csv_field_splitter_core #(
    parameter int FIELD_LIMIT = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [csvs_pkg::CNT_W-1:0] i_cfg_wdata,
    csvs_char_if.sink                       i_in,
    csvs_tok_if.source                      o_out
);
    import csvs_pkg::*;

    // the field cap is CNT_W bits wide, so a larger limit never binds
    localparam int              LIM_MAX = (1 << CNT_W) - 1;
    localparam int              LIM_CAP = (FIELD_LIMIT > LIM_MAX) ? LIM_MAX : FIELD_LIMIT;
    localparam logic [CNT_W-1:0] LIM    = LIM_CAP[CNT_W-1:0];

    logic [CNT_W-1:0]  r_field_cap;
    logic [CNT_W-1:0]  limit;

    // input stage
    logic              r_s1_valid, n_s1_valid;
    logic [CHAR_W-1:0] r_s1_ch;
    logic              r_s1_last;

    // result stage
    logic              r_out_valid, n_out_valid;
    t_result           r_res;
    t_result           res;

    logic              s1_adv;
    logic              in_take;

    // advance the input stage when the result register is free or being drained
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    assign limit = (r_field_cap > LIM) ? LIM : r_field_cap;

    csvs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_adv),
        .i_ch    (r_s1_ch),
        .i_last  (r_s1_last),
        .i_limit (limit),
        .o_res   (res)
    );

    always_comb begin
        n_s1_valid = i_in.ready ? i_in.valid : r_s1_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_field_cap <= FIELD_CAP_RST;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_field_cap <= i_cfg_wdata;
            end
        end
    end

    // payload: load on acceptance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ch   <= i_in.ch;
            r_s1_last <= i_in.last_char;
        end
        if (s1_adv) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_res.out_char;
    assign o_out.char_valid  = r_res.char_valid;
    assign o_out.field_index = r_res.field_index;
    assign o_out.field_end   = r_res.field_end;
    assign o_out.line_end    = r_res.line_end;
    assign o_out.field_count = r_res.field_count;
    assign o_out.error       = r_res.error;

    // content and field ends never appear once the line is in error
    `CSVS_ASSERT(a_no_content_in_error,
        (o_out.valid && o_out.error) |-> (!o_out.char_valid && !o_out.field_end),
        "content or field end flagged on an errored line")
    // the field count never passes the compile-time cap
    `CSVS_ASSERT(a_count_capped, o_out.valid |-> (o_out.field_count <= LIM),
        "field count beyond the limit")
    // a stalled result register keeps its item
    `CSVS_ASSERT(a_result_held,
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_res)),
        "result changed under stall")
    // both stages are empty right after reset
    `CSVS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_s1_valid && !r_out_valid),
        "stages not empty after reset")

endmodule

`default_nettype wire

// ===== tb/csv_field_splitter_core_test.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter_core_test
// Self-checking regression for the CSV field splitter. Lines of plain, quoted,
// empty and malformed fields are sent through the character channel. Each
// accepted character is run through a local parser model, and every returned
// token is compared field by field. Both channels idle at random, and the
// field limit is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module csv_field_splitter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import csvs_pkg::*;

    localparam int FIELD_LIMIT = 16;

    typedef logic [CHAR_W-1:0] t_line[$];

    // Parser position within the current field.
    typedef enum logic [1:0] {
        PH_FIELD_START,
        PH_PLAIN,
        PH_QUOTED,
        PH_QUOTE_SEEN
    } t_split_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    csvs_char_if char_ch ();
    csvs_tok_if  tok_ch ();

    csv_field_splitter_core #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (char_ch),
        .o_out       (tok_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Local copy of the parser state and of the field cap.
    t_split_phase     split_phase;
    logic [CNT_W-1:0] fields_open;
    logic             line_error;
    logic [CNT_W-1:0] field_cap_cfg;

    t_result     expected_tokens[$];
    t_result     exp_tok;
    int unsigned fail_count;
    int unsigned chars_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Advance the parser model by one character and return the token it yields.
    function automatic t_result predict_token(input logic [CHAR_W-1:0] c, input logic last);
        t_result          tok;
        logic [CNT_W-1:0] lim;
        lim = (field_cap_cfg < CNT_W'(FIELD_LIMIT)) ? field_cap_cfg : CNT_W'(FIELD_LIMIT);
        tok = '0;
        if (!line_error) begin
            case (split_phase)
                PH_FIELD_START: begin
                    // A field past the limit is not counted; the line is bad.
                    if (fields_open >= lim) begin
                        line_error = 1'b1;
                    end else begin
                        fields_open = fields_open + 1'b1;
                        if (c == QUOTE_CH) begin
                            split_phase = PH_QUOTED;
                        end else if (c == COMMA_CH) begin
                            // Empty field: open and close on the same comma.
                            tok.field_end = 1'b1;
                        end else begin
                            tok.out_char   = c;
                            tok.char_valid = 1'b1;
                            split_phase    = PH_PLAIN;
                        end
                    end
                end
                PH_PLAIN: begin
                    // A quote inside a plain field is ordinary content.
                    if (c == COMMA_CH) begin
                        tok.field_end = 1'b1;
                        split_phase   = PH_FIELD_START;
                    end else begin
                        tok.out_char   = c;
                        tok.char_valid = 1'b1;
                    end
                end
                PH_QUOTED: begin
                    // Hold back a quote until the next character decides.
                    if (c == QUOTE_CH) begin
                        split_phase = PH_QUOTE_SEEN;
                    end else begin
                        tok.out_char   = c;
                        tok.char_valid = 1'b1;
                    end
                end
                default: begin
                    if (c == QUOTE_CH) begin
                        tok.out_char   = QUOTE_CH;
                        tok.char_valid = 1'b1;
                        split_phase    = PH_QUOTED;
                    end else if (c == COMMA_CH) begin
                        tok.field_end = 1'b1;
                        split_phase   = PH_FIELD_START;
                    end else begin
                        // Junk after a closing quote.
                        line_error = 1'b1;
                    end
                end
            endcase
        end
        // The end of the line closes any field still open, quoted or not.
        if (last && !line_error && split_phase != PH_FIELD_START) begin
            tok.field_end = 1'b1;
        end
        tok.field_index = (fields_open == '0) ? '0 : IDX_W'(fields_open - 1'b1);
        tok.field_count = fields_open;
        tok.line_end    = last;
        tok.error       = line_error;
        if (last) begin
            split_phase = PH_FIELD_START;
            fields_open = '0;
            line_error  = 1'b0;
        end
        return tok;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Predict on every accepted character, then check every accepted token
    // against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                expected_tokens.push_back(predict_token(char_ch.ch, char_ch.last_char));
            end
            if (tok_ch.valid && tok_ch.ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token returned with no character outstanding");
                    fail_count++;
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    check_field("out_char", 32'(exp_tok.out_char), 32'(tok_ch.out_char));
                    check_field("char_valid", 32'(exp_tok.char_valid),
                                32'(tok_ch.char_valid));
                    check_field("field_index", 32'(exp_tok.field_index),
                                32'(tok_ch.field_index));
                    check_field("field_end", 32'(exp_tok.field_end), 32'(tok_ch.field_end));
                    check_field("line_end", 32'(exp_tok.line_end), 32'(tok_ch.line_end));
                    check_field("field_count", 32'(exp_tok.field_count),
                                32'(tok_ch.field_count));
                    check_field("error", 32'(exp_tok.error), 32'(tok_ch.error));
                end
            end
        end
    end

    // Stall the token channel at the rate set for the current phase.
    always @(posedge i_clk) begin
        tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Idle at random, then present one character and hold it until taken.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.ch        <= c;
        char_ch.last_char <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line(input t_line line);
        foreach (line[i]) begin
            send_char(line[i], i == line.size() - 1);
        end
    endtask

    function automatic t_line to_line(input string s);
        t_line q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Drop valid, wait for every outstanding token, then let the pipe settle.
    task automatic drain_results();
        char_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_field_cap(input logic [CNT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        field_cap_cfg = value;
    endtask

    // Mostly well-formed lines with random content; some raw noise, junk after
    // closing quotes, unclosed quotes and trailing commas.
    function automatic t_line random_line();
        t_line            q;
        int unsigned      eff;
        int unsigned      n_fields;
        int unsigned      len;
        int unsigned      kind;
        logic [CHAR_W-1:0] b;
        eff = (field_cap_cfg > FIELD_LIMIT) ? FIELD_LIMIT : field_cap_cfg;
        if ($urandom_range(99) < 10) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                case ($urandom_range(3))
                    0: q.push_back(QUOTE_CH);
                    1: q.push_back(COMMA_CH);
                    default: q.push_back(CHAR_W'($urandom_range(255)));
                endcase
            end
            return q;
        end
        n_fields = $urandom_range(1, eff + 2);
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0) q.push_back(COMMA_CH);
            kind = $urandom_range(3);
            if (kind == 1) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    b = CHAR_W'($urandom_range(255));
                    if (b == COMMA_CH || (k == 0 && b == QUOTE_CH)) begin
                        b = 8'h61 + CHAR_W'($urandom_range(25));
                    end
                    q.push_back(b);
                end
            end else if (kind >= 2) begin
                q.push_back(QUOTE_CH);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    case ($urandom_range(7))
                        0, 1: begin
                            q.push_back(QUOTE_CH);
                            q.push_back(QUOTE_CH);
                        end
                        2: q.push_back(COMMA_CH);
                        default: begin
                            b = CHAR_W'($urandom_range(255));
                            if (b == QUOTE_CH) b = 8'h20;
                            q.push_back(b);
                        end
                    endcase
                end
                // Leave the last field's quote open now and then.
                if (!(f == n_fields - 1 && $urandom_range(9) == 0)) begin
                    q.push_back(QUOTE_CH);
                    if ($urandom_range(9) == 0) begin
                        b = CHAR_W'($urandom_range(255));
                        if (b == QUOTE_CH || b == COMMA_CH) b = 8'h78;
                        q.push_back(b);
                    end
                end
            end
        end
        if ($urandom_range(9) == 0) q.push_back(COMMA_CH);
        if (q.size() == 0) q.push_back(COMMA_CH);
        return q;
    endfunction

    // Byte extremes, empty and quoted fields, doubled quotes, a quote inside a
    // plain field, junk after a closing quote, an unclosed quote, trailing comma.
    task automatic test_directed_lines();
        t_line line;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        line = {8'h00};
        send_line(line);
        line = {8'hFF, COMMA_CH};
        send_line(line);
        send_line(to_line(",\"a\"\"\",b\""));
        send_line(to_line("\"q\"x,"));
        send_line(to_line("\"op"));
        send_line(to_line("\"\""));
        drain_results();
    endtask

    // One field allowed, then none: the error hits at once.
    task automatic test_field_limit();
        set_field_cap(5'd1);
        send_line(to_line("a,b"));
        set_field_cap(5'd0);
        send_line(to_line("x"));
        drain_results();
    endtask

    task automatic test_random_lines(input logic [CNT_W-1:0] limit, input int unsigned idle,
                                     input int unsigned stall, input int unsigned n_chars);
        int unsigned start;
        set_field_cap(limit);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        start = chars_sent;
        while (chars_sent - start < n_chars) send_line(random_line());
        drain_results();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        char_ch.valid     = 1'b0;
        char_ch.ch        = '0;
        char_ch.last_char = 1'b0;
        split_phase       = PH_FIELD_START;
        fields_open       = '0;
        line_error        = 1'b0;
        field_cap_cfg     = FIELD_CAP_RST;
        fail_count        = 0;
        chars_sent        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_field_limit();
        // Sweep the limit through its extremes, varying the idling pattern between runs.
        test_random_lines(5'd8,  0,  0,  300);
        test_random_lines(5'd16, 87, 0,  250);
        test_random_lines(5'd1,  0,  87, 250);
        test_random_lines(5'd31, 28, 28, 300);
        test_random_lines(5'd0,  0,  0,  60);
        test_random_lines(5'd3,  28, 28, 250);
        test_random_lines(5'd16, 0,  0,  100);

        if (fail_count == 0) begin
            $display("csv_field_splitter_core regression: pass");
        end else begin
            $display("csv_field_splitter_core regression: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("csv_field_splitter_core regression: fail");
        $finish;
    end

endmodule
